@@ design/jsu_pkg.sv @@
package jsu_pkg;

   localparam int MAX_RESULTS = 3;
   localparam int QUEUE_DEPTH = 4;
   localparam int QIDX_W      = 2;
   localparam int QCNT_W      = 3;

   typedef enum logic [1:0] {
      PH_IDLE = 2'd0,
      PH_BODY = 2'd1,
      PH_ESC  = 2'd2,
      PH_HEX  = 2'd3
   } phase_type;

   typedef enum logic [1:0] {
      KIND_BYTE = 2'd0,
      KIND_DONE = 2'd1,
      KIND_ERR  = 2'd2
   } kind_type;

   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_CR     = 8'h0D;
   localparam logic [7:0] CH_U      = 8'h75;

   localparam logic [7:0]  UTF8_LEAD2     = 8'hC0;
   localparam logic [7:0]  UTF8_LEAD3     = 8'hE0;
   localparam logic [7:0]  UTF8_CONT      = 8'h80;
   localparam logic [7:0]  UTF8_CONT_MASK = 8'h3F;
   localparam logic [15:0] ONE_BYTE_LIMIT = 16'h0080;
   localparam logic [15:0] TWO_BYTE_LIMIT = 16'h0800;

   typedef struct packed {
      logic [7:0] out_byte;
      kind_type   kind;
      logic       last;
   } result_type;

   // up to three results caused by one input transaction
   typedef struct packed {
      result_type [MAX_RESULTS-1:0] res;
      logic [1:0]                   count;
   } dec_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic [QCNT_W-1:0] room;
   } q_status_type;

endpackage

@@ design/jsu_decode.sv @@
module jsu_decode (
   input  logic            clock,
   input  logic            reset,
   input  logic            advance,
   input  logic [7:0]      text_byte,
   input  logic            text_end,
   output jsu_pkg::dec_type   dec,
   output jsu_pkg::phase_type phase
);
   import jsu_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [1:0]  hex_seen_ff, hex_seen_in;
   logic [15:0] code_point_ff, code_point_in;

   logic        hex_ok;
   logic [3:0]  hex_val;
   logic        esc_ok;
   logic [7:0]  esc_byte;
   logic [15:0] cp_next;

   always_comb begin
      hex_ok  = 1'b1;
      hex_val = 4'd0;
      if (text_byte inside {[8'h30:8'h39]}) begin
         hex_val = 4'(text_byte - 8'h30);
      end else if (text_byte inside {[8'h61:8'h66]}) begin
         hex_val = 4'(text_byte - 8'h57);
      end else if (text_byte inside {[8'h41:8'h46]}) begin
         hex_val = 4'(text_byte - 8'h37);
      end else begin
         hex_ok = 1'b0;
      end
   end

   always_comb begin
      esc_ok   = 1'b1;
      esc_byte = 8'h00;
      case (text_byte)
         8'h22: esc_byte = 8'h22;
         8'h5C: esc_byte = 8'h5C;
         8'h2F: esc_byte = 8'h2F;
         8'h62: esc_byte = 8'h08;
         8'h66: esc_byte = 8'h0C;
         8'h6E: esc_byte = 8'h0A;
         8'h72: esc_byte = 8'h0D;
         8'h74: esc_byte = 8'h09;
         default: esc_ok = 1'b0;
      endcase
   end

   assign cp_next = {code_point_ff[11:0], hex_val};

   // next state
   always_comb begin
      logic fail;
      fail          = 1'b0;
      phase_in      = phase_ff;
      hex_seen_in   = hex_seen_ff;
      code_point_in = code_point_ff;
      if (advance) begin
         case (phase_ff)
            PH_IDLE: begin
               if (text_end) fail = 1'b1;
               else phase_in = PH_BODY;
            end
            PH_BODY: begin
               if (text_end || text_byte == CH_LF || text_byte == CH_CR) fail = 1'b1;
               else if (text_byte == CH_QUOTE) phase_in = PH_IDLE;
               else if (text_byte == CH_BSLASH) phase_in = PH_ESC;
            end
            PH_ESC: begin
               if (text_end) begin
                  fail = 1'b1;
               end else if (text_byte == CH_U) begin
                  phase_in      = PH_HEX;
                  hex_seen_in   = 2'd0;
                  code_point_in = 16'h0000;
               end else if (!esc_ok) begin
                  fail = 1'b1;
               end else begin
                  phase_in = PH_BODY;
               end
            end
            PH_HEX: begin
               if (text_end || !hex_ok) begin
                  fail = 1'b1;
               end else begin
                  code_point_in = cp_next;
                  if (hex_seen_ff == 2'd3) begin
                     hex_seen_in = 2'd0;
                     phase_in    = PH_BODY;
                  end else begin
                     hex_seen_in = hex_seen_ff + 2'd1;
                  end
               end
            end
            default: fail = 1'b1;
         endcase
         if (fail) begin
            phase_in      = PH_IDLE;
            hex_seen_in   = 2'd0;
            code_point_in = 16'h0000;
         end
      end
   end

   // results
   always_comb begin
      dec = '0;
      case (phase_ff)
         PH_IDLE: begin
            if (text_end) begin
               dec.count       = 2'd1;
               dec.res[0].kind = KIND_ERR;
            end
         end
         PH_BODY: begin
            dec.count = 2'd1;
            if (text_end || text_byte == CH_LF || text_byte == CH_CR) begin
               dec.res[0].kind = KIND_ERR;
            end else if (text_byte == CH_QUOTE) begin
               dec.res[0].kind = KIND_DONE;
            end else if (text_byte == CH_BSLASH) begin
               dec.count = 2'd0;
            end else begin
               dec.res[0].out_byte = text_byte;
            end
         end
         PH_ESC: begin
            if (text_end || (!esc_ok && text_byte != CH_U)) begin
               dec.count       = 2'd1;
               dec.res[0].kind = KIND_ERR;
            end else if (text_byte != CH_U) begin
               dec.count           = 2'd1;
               dec.res[0].out_byte = esc_byte;
            end
         end
         PH_HEX: begin
            if (text_end || !hex_ok) begin
               dec.count       = 2'd1;
               dec.res[0].kind = KIND_ERR;
            end else if (hex_seen_ff == 2'd3) begin
               if (cp_next < ONE_BYTE_LIMIT) begin
                  dec.count           = 2'd1;
                  dec.res[0].out_byte = cp_next[7:0];
               end else if (cp_next < TWO_BYTE_LIMIT) begin
                  dec.count           = 2'd2;
                  dec.res[0].out_byte = UTF8_LEAD2 | {3'b000, cp_next[10:6]};
                  dec.res[1].out_byte = UTF8_CONT | ({2'b00, cp_next[5:0]} & UTF8_CONT_MASK);
               end else begin
                  dec.count           = 2'd3;
                  dec.res[0].out_byte = UTF8_LEAD3 | {4'b0000, cp_next[15:12]};
                  dec.res[1].out_byte = UTF8_CONT | ({2'b00, cp_next[11:6]} & UTF8_CONT_MASK);
                  dec.res[2].out_byte = UTF8_CONT | ({2'b00, cp_next[5:0]} & UTF8_CONT_MASK);
               end
            end
         end
         default: dec = '0;
      endcase
      case (dec.count)
         2'd1: dec.res[0].last = 1'b1;
         2'd2: dec.res[1].last = 1'b1;
         2'd3: dec.res[2].last = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         hex_seen_ff   <= 2'd0;
         code_point_ff <= 16'h0000;
      end else begin
         phase_ff      <= phase_in;
         hex_seen_ff   <= hex_seen_in;
         code_point_ff <= code_point_in;
      end
   end

   assign phase = phase_ff;

endmodule

@@ design/jsu_res_queue.sv @@
module jsu_res_queue (
   input  logic                                        clock,
   input  logic                                        reset,
   input  logic                                        pop,
   input  logic [1:0]                                  push_cnt,
   input  jsu_pkg::result_type [jsu_pkg::MAX_RESULTS-1:0] push_res,
   output jsu_pkg::result_type                         head,
   output jsu_pkg::q_status_type                       status
);
   import jsu_pkg::*;

   result_type [QUEUE_DEPTH-1:0] slots_ff, slots_in;
   logic [QCNT_W-1:0]            count_ff, count_in;
   logic [QCNT_W-1:0]            keep;

   // shift out the head on pop, append new results behind what remains
   always_comb begin
      logic [QCNT_W-1:0] src;
      logic [QCNT_W-1:0] dst;
      keep     = count_ff - {{(QCNT_W-1){1'b0}}, pop};
      slots_in = slots_ff;
      for (int i = 0; i < QUEUE_DEPTH; i++) begin
         src = QCNT_W'(i) + {{(QCNT_W-1){1'b0}}, pop};
         dst = QCNT_W'(i) - keep;
         if (src < count_ff) begin
            slots_in[i] = slots_ff[src[QIDX_W-1:0]];
         end else if (dst < {1'b0, push_cnt}) begin
            slots_in[i] = push_res[dst[1:0]];
         end
      end
      count_in = keep + {1'b0, push_cnt};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      slots_ff <= slots_in;
   end

   assign head         = slots_ff[0];
   assign status.count = count_ff;
   assign status.room  = QCNT_W'(QUEUE_DEPTH) - keep;

endmodule

@@ design/json_string_unescape_top.sv @@
// Path: a req transaction is registered in the input stage, then in the result queue.
// Throughput: one req transaction per cycle while rsp is taken every cycle; a \u
//   escape above 0x7FF yields three results drained one per cycle from a 4-entry
//   result queue, so the input stalls once that queue cannot hold an item's results.
// Reset: synchronous, active high; clears decoder state to idle and empties both stages.
module json_string_unescape_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] text_byte
   input  logic [0:0]  req_tuser,   // [0] text_end
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,   // [7:0] out_byte
   output logic [1:0]  rsp_tuser,   // [1:0] result_kind
   output logic        rsp_tlast    // last_of_run
);
   import jsu_pkg::*;

   logic         in_valid_ff, in_valid_in;
   logic [7:0]   in_byte_ff;
   logic         in_end_ff;
   logic         accept;
   logic         consume;
   logic         pop;
   logic [1:0]   push_cnt;
   dec_type      dec;
   phase_type    phase;
   result_type   head;
   q_status_type q_stat;

   assign pop        = rsp_tvalid && rsp_tready;
   assign consume    = in_valid_ff && ({1'b0, dec.count} <= q_stat.room);
   assign req_tready = !in_valid_ff || consume;
   assign accept     = req_tvalid && req_tready;
   assign push_cnt   = consume ? dec.count : 2'd0;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (accept) in_valid_in = 1'b1;
      else if (consume) in_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_byte_ff <= req_tdata;
         in_end_ff  <= req_tuser[0];
      end
   end

   jsu_decode u_decode (
      .clock     (clock),
      .reset     (reset),
      .advance   (consume),
      .text_byte (in_byte_ff),
      .text_end  (in_end_ff),
      .dec       (dec),
      .phase     (phase)
   );

   jsu_res_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .pop      (pop),
      .push_cnt (push_cnt),
      .push_res (dec.res),
      .head     (head),
      .status   (q_stat)
   );

   assign rsp_tvalid = (q_stat.count != '0);
   assign rsp_tdata  = head.out_byte;
   assign rsp_tuser  = head.kind;
   assign rsp_tlast  = head.last;

   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      q_stat.count <= QCNT_W'(QUEUE_DEPTH))
      else $error("result queue over capacity");

   a_err_to_idle: assert property (@(posedge clock) disable iff (reset)
      consume && dec.count != 2'd0 && dec.res[0].kind == KIND_ERR |=> phase == PH_IDLE)
      else $error("decoder not idle after error");

   a_no_load_over_held: assert property (@(posedge clock) disable iff (reset)
      accept |-> !in_valid_ff || consume)
      else $error("input register overwritten");

   a_kind_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3)
      else $error("illegal result kind");

   a_byte_zero_nonbyte: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_BYTE |-> rsp_tdata == 8'h00 && rsp_tlast)
      else $error("status result with data or not last");

endmodule
